// ===== rtl/lkv_pkg.sv =====
package lkv_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RANK_W      = IDX_W;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W       = 5;
	localparam int CAP_RESET   = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CMP_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} dp_ctrl_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// LRU key/value cache, 16 entries, fully associative.
// Slave channel s_*: one request per item. s_tuser is the command
// (0 get, 1 put); s_tdata carries lookup_key in [31:0], write_value in [63:32].
// Master channel m_*: one result per request, in request order. m_tuser is
// the hit flag; m_tdata is the stored value on a get hit and zero otherwise.
// cfg_we/cfg_wdata write active_capacity (1..16, 0 acts as 1, above 16 as 16);
// write only while no request is in flight.
// A request is registered on acceptance, looked up in the tag compare state and
// written to the output register in the rank update/write state once that
// register is free. The compare and update/write states share the entry table;
// a new request is taken in the update cycle, never in the compare cycle.
// A result waiting on m_tready is held in the output register; one more
// request is accepted and looked up, then the block holds in its update
// cycle until the output frees up.
// Reset (arst_n low) empties the cache, restores capacity 16 and drops any
// pending result.
module lru_key_value_cache (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [63:0]               s_tdata,   // lookup_key, write_value
	input  logic                      s_tuser,   // command
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,   // read_value
	output logic                      m_tuser,   // hit
	input  logic                      cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);

	lkv_pkg::dp_ctrl_t ctrl;

	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctrl     (ctrl)
	);

	lkv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_cmd   (s_tuser),
		.req_key   (s_tdata[31:0]),
		.req_val   (s_tdata[63:32]),
		.rsp_hit   (m_tuser),
		.rsp_val   (m_tdata)
	);

endmodule

// ===== rtl/lkv_ctrl.sv =====
module lkv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output lkv_pkg::dp_ctrl_t ctrl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   m_valid_q;
	logic   out_free, commit, accept;

	assign out_free = !m_valid_q || m_tready;
	assign commit   = (state_q == ST_UPD) && out_free;
	assign s_tready = (state_q == ST_IDLE) || commit;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;

	assign ctrl.load   = accept;
	assign ctrl.lookup = (state_q == ST_CMP);
	assign ctrl.commit = commit;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (commit) state_d = accept ? ST_CMP : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/lkv_dp.sv =====
module lkv_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lkv_pkg::dp_ctrl_t           ctrl,
	input  logic                        cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                        req_cmd,
	input  logic [lkv_pkg::KEY_W-1:0]   req_key,
	input  logic [lkv_pkg::VAL_W-1:0]   req_val,
	output logic                        rsp_hit,
	output logic [lkv_pkg::VAL_W-1:0]   rsp_val
);

	localparam int N = lkv_pkg::MAX_ENTRIES;

	logic [lkv_pkg::KEY_W-1:0]  keys_q  [N];
	logic [lkv_pkg::VAL_W-1:0]  vals_q  [N];
	logic [lkv_pkg::RANK_W-1:0] rank_q  [N];
	logic [N-1:0]               valid_q;
	logic [lkv_pkg::CNT_W-1:0]  live_q;
	logic [lkv_pkg::CAP_W-1:0]  cap_q;

	logic                       req_put_q;
	logic [lkv_pkg::KEY_W-1:0]  req_key_q;
	logic [lkv_pkg::VAL_W-1:0]  req_val_q;

	logic [N-1:0]               match_s1, victim_s1, slot_s1;
	logic                       hit_s1, evict_s1;
	logic [lkv_pkg::RANK_W-1:0] found_rank_s1;
	logic [lkv_pkg::VAL_W-1:0]  rd_value_s1;

	logic                       hit_q;
	logic [lkv_pkg::VAL_W-1:0]  rd_q;

	logic [N-1:0]               match, match_1h, victim, free_mask, slot_1h;
	logic                       hit, evict;
	logic [lkv_pkg::RANK_W-1:0] found_rank, last_rank;
	logic [lkv_pkg::VAL_W-1:0]  rd_value;
	logic [lkv_pkg::CMP_W-1:0]  cap_x, live_x, eff_x;

	assign cap_x = lkv_pkg::CMP_W'(cap_q);
	assign live_x = lkv_pkg::CMP_W'(live_q);

	always_comb begin
		if (cap_x == '0) eff_x = lkv_pkg::CMP_W'(1);
		else if (cap_x > lkv_pkg::CMP_W'(N)) eff_x = lkv_pkg::CMP_W'(N);
		else eff_x = cap_x;
	end

	assign last_rank = lkv_pkg::RANK_W'(live_q - lkv_pkg::CNT_W'(1));

	always_comb begin
		for (int i = 0; i < N; i++) begin
			match[i]  = valid_q[i] && (keys_q[i] == req_key_q);
			victim[i] = valid_q[i] && (rank_q[i] == last_rank);
		end
	end

	assign match_1h = match & (~match + N'(1));
	assign hit      = |match;
	assign evict    = (req_put_q == lkv_pkg::CMD_PUT) && !hit && (live_x >= eff_x);
	assign free_mask = ~valid_q | (evict ? victim : '0);
	assign slot_1h  = free_mask & (~free_mask + N'(1));

	always_comb begin
		found_rank = '0;
		rd_value   = '0;
		for (int i = 0; i < N; i++) begin
			if (match_1h[i]) begin
				found_rank = found_rank | rank_q[i];
				rd_value   = rd_value | vals_q[i];
			end
		end
		if (req_put_q == lkv_pkg::CMD_PUT) rd_value = '0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			req_put_q <= req_cmd;
			req_key_q <= req_key;
			req_val_q <= req_val;
		end
		if (ctrl.lookup) begin
			match_s1      <= match_1h;
			victim_s1     <= victim;
			slot_s1       <= slot_1h;
			hit_s1        <= hit;
			evict_s1      <= evict;
			found_rank_s1 <= found_rank;
			rd_value_s1   <= rd_value;
		end
		if (ctrl.commit) begin
			hit_q <= hit_s1;
			rd_q  <= rd_value_s1;
			for (int i = 0; i < N; i++) begin
				if (hit_s1) begin
					if (match_s1[i]) begin
						rank_q[i] <= '0;
						if (req_put_q == lkv_pkg::CMD_PUT) vals_q[i] <= req_val_q;
					end else if (valid_q[i] && (rank_q[i] < found_rank_s1)) begin
						rank_q[i] <= rank_q[i] + lkv_pkg::RANK_W'(1);
					end
				end else if (req_put_q == lkv_pkg::CMD_PUT) begin
					if (slot_s1[i]) begin
						keys_q[i] <= req_key_q;
						vals_q[i] <= req_val_q;
						rank_q[i] <= '0;
					end else if (valid_q[i] && !(evict_s1 && victim_s1[i])) begin
						rank_q[i] <= rank_q[i] + lkv_pkg::RANK_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			cap_q   <= lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (ctrl.commit && !hit_s1 && (req_put_q == lkv_pkg::CMD_PUT)) begin
				valid_q <= (valid_q & ~(evict_s1 ? victim_s1 : '0)) | slot_s1;
				if (!evict_s1) live_q <= live_q + lkv_pkg::CNT_W'(1);
			end
		end
	end

	assign rsp_hit = hit_q;
	assign rsp_val = rd_q;

endmodule

// ===== rtl/lkv_checker.sv =====
module lkv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// misses carry zero data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'd0)
		else $error("miss with nonzero data");

	// no request is accepted in the lookup cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted in lookup cycle");

	// a request is followed by a pending result on m_tvalid
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##3 m_tvalid)
		else $error("no result after request");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
